// ===== src/fbrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_pkg
// shared types and codes for the frame store fill engine
// ----------------------------------------------------------------------------
package fbrf_pkg;

    localparam int COORD_W = 8;
    localparam int PIXEL_W = 24;
    localparam int COUNT_W = 15;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // item modes
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FILL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic clr_step;
        logic wr_pixel;
        logic rd_pixel;
        logic fill_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic              clear_last;
        logic [MODE_W-1:0] mode;
        logic              in_frame;
        logic              rect_empty;
        logic              fill_last;
        logic              out_free;
    } t_dp_status;

endpackage

// ===== src/fbrf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
module fbrf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fbrf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_datapath
// item registers, config registers, raster counters, frame store, output word
// ----------------------------------------------------------------------------
module fbrf_datapath #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fbrf_pkg::t_dp_cmd                      i_cmd,
    output fbrf_pkg::t_dp_status                   o_status,
    input  logic                                   i_in_valid,
    input  logic [fbrf_pkg::MODE_W-1:0]            i_in_mode,
    input  logic [55:0]                            i_in_data,
    input  logic                                   i_cfg_valid,
    input  logic [fbrf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [7:0]                             i_cfg_data,
    input  logic                                   i_m_tready,
    output logic                                   o_m_tvalid,
    output logic [fbrf_pkg::PIXEL_W-1:0]           o_pixel_value,
    output logic                                   o_out_of_range,
    output logic [fbrf_pkg::COUNT_W-1:0]           o_pixels_written
);
    import fbrf_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW     = AW + COORD_W + 1;
    localparam int MW_CAP = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
    localparam int MH_CAP = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;

    // config
    logic [COORD_W-1:0] r_cfg_width;
    logic [COORD_W-1:0] r_cfg_height;
    logic               r_cfg_format;

    // item
    logic [MODE_W-1:0]  r_mode;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_col_start;
    logic [COORD_W-1:0] r_row_end;
    logic [COORD_W-1:0] r_col_end;
    logic [7:0]         r_red;
    logic [7:0]         r_green;
    logic [7:0]         r_blue;
    logic [COUNT_W-1:0] r_count;

    logic [AW-1:0]      r_clr_addr;

    logic               r_out_valid;
    logic [PIXEL_W-1:0] r_out_value;
    logic               r_out_oor;
    logic [COUNT_W-1:0] r_out_count;

    logic [COORD_W-1:0] eff_w;
    logic [COORD_W-1:0] eff_h;
    logic [COORD_W-1:0] row_hi;
    logic [COORD_W-1:0] col_hi;
    logic               in_frame;
    logic               col_wrap;
    logic [PW-1:0]      addr_full;
    logic [AW-1:0]      pix_addr;
    logic [PIXEL_W-1:0] pixel_word;
    logic [PIXEL_W-1:0] rdata;
    logic               accept;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [PIXEL_W-1:0] ram_wdata;
    logic               out_free;

    assign accept = i_cmd.in_ready & i_in_valid;

    // frame in use, clamped to the store
    assign eff_w  = (r_cfg_width  > COORD_W'(MW_CAP)) ? COORD_W'(MW_CAP) : r_cfg_width;
    assign eff_h  = (r_cfg_height > COORD_W'(MH_CAP)) ? COORD_W'(MH_CAP) : r_cfg_height;
    assign row_hi = (r_row_end < eff_h) ? r_row_end : eff_h;
    assign col_hi = (r_col_end < eff_w) ? r_col_end : eff_w;
    assign in_frame = (r_row < eff_h) && (r_col < eff_w);
    assign col_wrap = ({1'b0, r_col} + 9'd1) == {1'b0, col_hi};

    // row-major address, one constant multiply
    assign addr_full = PW'(r_row) * PW'(MAX_WIDTH) + PW'(r_col);
    assign pix_addr  = addr_full[AW-1:0];

    assign pixel_word = r_cfg_format ?
        {8'd0, r_red[7:3], r_green[7:2], r_blue[7:3]} : {r_red, r_green, r_blue};

    assign ram_we    = i_cmd.clr_step | i_cmd.wr_pixel | i_cmd.fill_step;
    assign ram_addr  = i_cmd.clr_step ? r_clr_addr : pix_addr;
    assign ram_wdata = i_cmd.clr_step ? '0 : pixel_word;

    fbrf_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (i_cmd.rd_pixel),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= 8'd128;
            r_cfg_height <= 8'd128;
            r_cfg_format <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                CFG_FORMAT: r_cfg_format <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // item capture and raster walk
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode      <= i_in_mode;
            r_row       <= i_in_data[7:0];
            r_col       <= i_in_data[15:8];
            r_col_start <= i_in_data[15:8];
            r_row_end   <= i_in_data[23:16];
            r_col_end   <= i_in_data[31:24];
            r_red       <= i_in_data[39:32];
            r_green     <= i_in_data[47:40];
            r_blue      <= i_in_data[55:48];
            r_count     <= '0;
        end else begin
            if (i_cmd.wr_pixel || i_cmd.fill_step) begin
                if (r_count != COUNT_MAX) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end
            if (i_cmd.fill_step) begin
                if (col_wrap) begin
                    r_col <= r_col_start;
                    r_row <= r_row + COORD_W'(1);
                end else begin
                    r_col <= r_col + COORD_W'(1);
                end
            end
        end
    end

    // output word register
    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value <= (r_mode == MODE_READ && in_frame) ? rdata : '0;
            r_out_oor   <= (r_mode == MODE_WRITE || r_mode == MODE_READ) && !in_frame;
            r_out_count <= r_count;
        end
    end

    assign o_m_tvalid       = r_out_valid;
    assign o_pixel_value    = r_out_value;
    assign o_out_of_range   = r_out_oor;
    assign o_pixels_written = r_out_count;

    assign o_status.clear_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_status.mode       = r_mode;
    assign o_status.in_frame   = in_frame;
    assign o_status.rect_empty = !((r_row < row_hi) && (r_col < col_hi));
    assign o_status.fill_last  = col_wrap && (({1'b0, r_row} + 9'd1) == {1'b0, row_hi});
    assign o_status.out_free   = out_free;

    // raster walk stays within the clipped rectangle
    a_fill_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_step |-> (r_row < row_hi) && (r_col < col_hi))
        else $error("fill step outside clipped rectangle");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");

    a_single_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out && r_mode != MODE_FILL |-> r_count <= COUNT_W'(1))
        else $error("non-fill item counted more than one pixel");

endmodule

// ===== src/fbrf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_ctrl
// sequencer for clearing pass, item dispatch, fill walk and result hand-off
// ----------------------------------------------------------------------------
module fbrf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  fbrf_pkg::t_dp_status i_status,
    output fbrf_pkg::t_dp_cmd    o_cmd
);
    import fbrf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_status.mode == MODE_FILL && !i_status.rect_empty) begin
                    n_state = ST_FILL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_FILL: begin
                if (i_status.fill_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE:  o_cmd.in_ready = 1'b1;
            ST_EXEC: begin
                o_cmd.wr_pixel = (i_status.mode == MODE_WRITE) && i_status.in_frame;
                o_cmd.rd_pixel = (i_status.mode == MODE_READ) && i_status.in_frame;
            end
            ST_FILL:  o_cmd.fill_step = 1'b1;
            ST_DONE:  o_cmd.load_out = i_status.out_free;
            default:  o_cmd = '0;
        endcase
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state == ST_CLEAR)
        else $error("reset did not start clearing pass");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_status.out_free)
        else $error("result loaded over an untaken word");

    a_fill_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fill_step |-> !i_status.rect_empty)
        else $error("fill step on empty rectangle");

endmodule

// ===== src/framebuffer_rect_fill_rgb565_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_rect_fill_rgb565_core
// frame store with single-pixel write, rectangle fill and pixel read
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                  | word
//  ----------+-----------+----------------------------+---------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tuser mode, tdata coords+rgb
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tuser out_of_range, tdata
//  cfg       | in        | i_cfg_valid/o_cfg_ready     | index, 8-bit value
//
//  steps: an item passes through EXEC and DONE; a non-empty fill adds a FILL walk over
//  its clipped area, one pixel per cycle through the single store port
//  reset: a clearing pass writes zero to every store entry, MAX_WIDTH*MAX_HEIGHT
//  entries (16384 by default); no word is taken until it ends, config is taken
//  stalls: the next word is taken while a result waits in the output register;
//  the finished item then waits until that result is taken
// ----------------------------------------------------------------------------
module framebuffer_rect_fill_rgb565_core #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] mode
    input  logic [fbrf_pkg::MODE_W-1:0]         s_axis_tuser,
    // [7:0] row_start, [15:8] col_start, [23:16] row_end, [31:24] col_end,
    // [39:32] red, [47:40] green, [55:48] blue
    input  logic [55:0]                         s_axis_tdata,
    // result
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] out_of_range
    output logic                                m_axis_tuser,
    // [23:0] pixel_value, [38:24] pixels_written, [39] zero
    output logic [39:0]                         m_axis_tdata,
    // config writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fbrf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                          i_cfg_data
);
    import fbrf_pkg::*;

    t_dp_cmd            cmd;
    t_dp_status         status;
    logic [PIXEL_W-1:0] pixel_value;
    logic [COUNT_W-1:0] pixels_written;

    // config is always taken, block is idle by contract
    assign o_cfg_ready = 1'b1;

    fbrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fbrf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_in_valid       (s_axis_tvalid),
        .i_in_mode        (s_axis_tuser),
        .i_in_data        (s_axis_tdata),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_m_tready       (m_axis_tready),
        .o_m_tvalid       (m_axis_tvalid),
        .o_pixel_value    (pixel_value),
        .o_out_of_range   (m_axis_tuser),
        .o_pixels_written (pixels_written)
    );

    assign s_axis_tready = cmd.in_ready;

    // pad to whole bytes
    assign m_axis_tdata = {1'b0, pixels_written, pixel_value};

endmodule
